// ----- design/date_record_sorter_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Date record sorter assertion macros
// Shared concurrent assertion forms used by the sorter RTL.
// ----------------------------------------------------------------------------
`ifndef DATE_RECORD_SORTER_UNIT_DEFINES_SVH
`define DATE_RECORD_SORTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DSORT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define DSORT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/dsort_pkg.sv -----
// ----------------------------------------------------------------------------
// Date record sorter package
// Record layout, validity limits and the sort key.
// ----------------------------------------------------------------------------
package dsort_pkg;

   localparam int          MAX_RECORDS_DEF  = 64;
   localparam logic [11:0] YEAR_LIMIT_RESET = 12'd2023;
   localparam logic [5:0]  DAY_MAX          = 6'd31;
   localparam logic [3:0]  MONTH_MAX        = 4'd12;

   typedef struct packed {
      logic [7:0]  tag;
      logic [5:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
   } rec_type;

   typedef logic [21:0] key_type;

   // Year is the most significant part, then month, then day.
   function automatic key_type rec_key(input rec_type r);
      rec_key = {r.year, r.month, r.day};
   endfunction

   function automatic logic rec_ok(input rec_type r, input logic [11:0] limit);
      rec_ok = (r.day <= DAY_MAX) && (r.month <= MONTH_MAX) && (r.year <= limit);
   endfunction

endpackage

// ----- design/date_record_sorter_unit.sv -----
// Loading: req is taken while idle; a record beyond MAX_RECORDS is dropped.
// Sorting: one key compare at a time on the single read port of the record
// memory. Emitting: each stored record is read in turn, held while a result
// waits and rsp_ready is low. No req transfer is taken from the last-marked
// record until the final result is presented. Synchronous reset clears
// control state and sets year_limit to 2023; memory is not cleared.
// ----------------------------------------------------------------------------
// Date record sorter unit
// Collects date records, exchange-sorts them by (year, month, day) with one
// shared comparator, then streams out the valid ones with sorted positions.
// ----------------------------------------------------------------------------
`include "date_record_sorter_unit_defines.svh"

module date_record_sorter_unit
   import dsort_pkg::*;
#(
   parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_tag,
   input  logic [5:0]                         req_day,
   input  logic [3:0]                         req_month,
   input  logic [11:0]                        req_year,
   input  logic                               req_is_last,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [$clog2(MAX_RECORDS+1)-1:0]   rsp_position,
   output logic [7:0]                         rsp_out_tag,
   output logic [4:0]                         rsp_out_day,
   output logic [3:0]                         rsp_out_month,
   output logic [11:0]                        rsp_out_year,
   output logic                               rsp_has_record,
   output logic                               rsp_final_res,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [11:0]                        csr_year_limit
);

   localparam int IDXW = $clog2(MAX_RECORDS);
   localparam int CNTW = $clog2(MAX_RECORDS + 1);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_SORT_RI = 9'b000000010,
      ST_SORT_LI = 9'b000000100,
      ST_SORT_RJ = 9'b000001000,
      ST_SORT_CJ = 9'b000010000,
      ST_SORT_WI = 9'b000100000,
      ST_EMIT_RD = 9'b001000000,
      ST_EMIT_CK = 9'b010000000,
      ST_EMIT_END = 9'b100000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic [CNTW-1:0]  n_ff, n_in;
   logic [IDXW-1:0]  i_ff, i_in;
   logic [IDXW-1:0]  j_ff, j_in;
   logic [IDXW-1:0]  k_ff, k_in;
   rec_type          cur_ff, cur_in;
   logic [11:0]      year_limit_ff;

   logic             pend_valid_ff, pend_valid_in;
   rec_type          pend_ff, pend_in;
   logic [CNTW-1:0]  pend_pos_ff, pend_pos_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNTW-1:0]  out_pos_ff, out_pos_in;
   rec_type          out_rec_ff, out_rec_in;
   logic             out_has_ff, out_has_in;
   logic             out_final_ff, out_final_in;

   rec_type          mem [MAX_RECORDS];
   rec_type          rd_data_ff;
   logic [IDXW-1:0]  rd_addr;
   logic             wr_en;
   logic [IDXW-1:0]  wr_addr;
   rec_type          wr_data;

   logic             out_free;
   logic [CNTW-1:0]  n_new;
   logic             rd_ok;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rd_ok     = rec_ok(rd_data_ff, year_limit_ff);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_position   = out_pos_ff;
   assign rsp_out_tag    = out_rec_ff.tag;
   assign rsp_out_day    = out_rec_ff.day[4:0];
   assign rsp_out_month  = out_rec_ff.month;
   assign rsp_out_year   = out_rec_ff.year;
   assign rsp_has_record = out_has_ff;
   assign rsp_final_res  = out_final_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      cur_in        = cur_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      pend_pos_in   = pend_pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      out_pos_in    = out_pos_ff;
      out_rec_in    = out_rec_ff;
      out_has_in    = out_has_ff;
      out_final_in  = out_final_ff;
      rd_addr       = i_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDXW-1:0];
      wr_data       = {req_tag, req_day, req_month, req_year};
      n_new         = count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (count_ff < CNTW'(MAX_RECORDS)) begin
                  wr_en = 1'b1;
                  n_new = count_ff + CNTW'(1);
               end
               count_in = n_new;
               if (req_is_last) begin
                  n_in          = n_new;
                  i_in          = '0;
                  k_in          = '0;
                  pend_valid_in = 1'b0;
                  state_in      = (n_new < CNTW'(2)) ? ST_EMIT_RD : ST_SORT_RI;
               end
            end
         end
         ST_SORT_RI: begin
            rd_addr  = i_ff;
            state_in = ST_SORT_LI;
         end
         ST_SORT_LI: begin
            cur_in   = rd_data_ff;
            j_in     = i_ff + IDXW'(1);
            state_in = ST_SORT_RJ;
         end
         ST_SORT_RJ: begin
            rd_addr  = j_ff;
            state_in = ST_SORT_CJ;
         end
         ST_SORT_CJ: begin
            rd_addr = j_ff;
            if (rec_key(rd_data_ff) < rec_key(cur_ff)) begin
               wr_en   = 1'b1;
               wr_addr = j_ff;
               wr_data = cur_ff;
               cur_in  = rd_data_ff;
            end
            if (CNTW'(j_ff) == n_ff - CNTW'(1)) begin
               state_in = ST_SORT_WI;
            end else begin
               j_in     = j_ff + IDXW'(1);
               state_in = ST_SORT_RJ;
            end
         end
         ST_SORT_WI: begin
            wr_en   = 1'b1;
            wr_addr = i_ff;
            wr_data = cur_ff;
            if (CNTW'(i_ff) == n_ff - CNTW'(2)) begin
               k_in     = '0;
               state_in = ST_EMIT_RD;
            end else begin
               i_in     = i_ff + IDXW'(1);
               state_in = ST_SORT_RI;
            end
         end
         ST_EMIT_RD: begin
            rd_addr  = k_ff;
            state_in = ST_EMIT_CK;
         end
         ST_EMIT_CK: begin
            rd_addr = k_ff;
            if (!(rd_ok && pend_valid_ff && !out_free)) begin
               if (rd_ok) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     out_pos_in   = pend_pos_ff;
                     out_rec_in   = pend_ff;
                     out_has_in   = 1'b1;
                     out_final_in = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_in       = rd_data_ff;
                  pend_pos_in   = CNTW'(k_ff) + CNTW'(1);
               end
               if (CNTW'(k_ff) == n_ff - CNTW'(1)) begin
                  state_in = ST_EMIT_END;
               end else begin
                  k_in     = k_ff + IDXW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         ST_EMIT_END: begin
            rd_addr = k_ff;
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_final_in  = 1'b1;
               out_has_in    = pend_valid_ff;
               out_pos_in    = pend_valid_ff ? pend_pos_ff : '0;
               out_rec_in    = pend_valid_ff ? pend_ff : '0;
               pend_valid_in = 1'b0;
               count_in      = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         year_limit_ff <= YEAR_LIMIT_RESET;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            year_limit_ff <= csr_year_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      cur_ff       <= cur_in;
      pend_ff      <= pend_in;
      pend_pos_ff  <= pend_pos_in;
      out_pos_ff   <= out_pos_in;
      out_rec_ff   <= out_rec_in;
      out_has_ff   <= out_has_in;
      out_final_ff <= out_final_in;
   end

   `DSORT_ASSERT_NOW(a_marker_is_final, clock, reset, rsp_valid_ff && !out_has_ff, out_final_ff, "marker result without final flag")
   `DSORT_ASSERT_NOW(a_inner_after_outer, clock, reset, state_ff == ST_SORT_CJ, j_ff > i_ff, "inner index not beyond outer index")
   `DSORT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNTW'(MAX_RECORDS), "record count beyond capacity")
   `DSORT_ASSERT_NEXT(a_batch_done, clock, reset, state_ff == ST_EMIT_END && out_free, state_ff == ST_IDLE && count_ff == '0 && rsp_valid_ff && out_final_ff, "batch end did not return to idle")

endmodule

// ----- bench/date_record_sorter_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date record sorter unit testbench
// Sends batches of date records, predicts the sorted output of each batch with
// an exchange sort of its own, and checks every result transfer in order.
// Runs under several year limits with sender and receiver gaps.
// ----------------------------------------------------------------------------
module date_record_sorter_unit_test;
   import dsort_pkg::*;

   localparam int STALL_LIMIT = 40000;

   typedef struct {
      logic [6:0]  position;
      logic [7:0]  tag;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
      logic        has_record;
      logic        final_res;
   } dated_entry_type;

   class date_order_board;
      rec_type         batch[$];
      dated_entry_type awaited[$];
      logic [11:0]     year_limit;
      int              errors;

      function new();
         year_limit = YEAR_LIMIT_RESET;
         errors = 0;
      endfunction

      function void note_record(rec_type r, logic last);
         rec_type         sorted[$];
         rec_type         swap;
         dated_entry_type entry;
         int              listed;
         if (batch.size() < MAX_RECORDS_DEF) begin
            batch.push_back(r);
         end
         if (!last) begin
            return;
         end
         sorted = batch;
         for (int i = 0; i + 1 < sorted.size(); i++) begin
            for (int j = i + 1; j < sorted.size(); j++) begin
               if ({sorted[j].year, sorted[j].month, sorted[j].day} <
                   {sorted[i].year, sorted[i].month, sorted[i].day}) begin
                  swap = sorted[i];
                  sorted[i] = sorted[j];
                  sorted[j] = swap;
               end
            end
         end
         listed = 0;
         foreach (sorted[i]) begin
            if (sorted[i].day <= DAY_MAX && sorted[i].month <= MONTH_MAX &&
                sorted[i].year <= year_limit) begin
               entry.position = 7'(i + 1);
               entry.tag = sorted[i].tag;
               entry.day = sorted[i].day[4:0];
               entry.month = sorted[i].month;
               entry.year = sorted[i].year;
               entry.has_record = 1'b1;
               entry.final_res = 1'b0;
               awaited.push_back(entry);
               listed++;
            end
         end
         if (listed == 0) begin
            entry.position = '0;
            entry.tag = '0;
            entry.day = '0;
            entry.month = '0;
            entry.year = '0;
            entry.has_record = 1'b0;
            entry.final_res = 1'b1;
            awaited.push_back(entry);
         end else begin
            awaited[awaited.size() - 1].final_res = 1'b1;
         end
         batch.delete();
      endfunction

      function void check_result(dated_entry_type got);
         dated_entry_type want;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("unexpected result: pos %0d tag %0d %0d-%0d-%0d rec %0b last %0b",
                        got.position, got.tag, got.year, got.month, got.day,
                        got.has_record, got.final_res);
            end
            return;
         end
         want = awaited.pop_front();
         if (got.position !== want.position || got.tag !== want.tag ||
             got.day !== want.day || got.month !== want.month ||
             got.year !== want.year || got.has_record !== want.has_record ||
             got.final_res !== want.final_res) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch: expected pos %0d tag %0d %0d-%0d-%0d rec %0b last %0b",
                        want.position, want.tag, want.year, want.month, want.day,
                        want.has_record, want.final_res);
               $display("          actual   pos %0d tag %0d %0d-%0d-%0d rec %0b last %0b",
                        got.position, got.tag, got.year, got.month, got.day,
                        got.has_record, got.final_res);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_tag = '0;
   logic [5:0]  req_day = '0;
   logic [3:0]  req_month = '0;
   logic [11:0] req_year = '0;
   logic        req_is_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [6:0]  rsp_position;
   logic [7:0]  rsp_out_tag;
   logic [4:0]  rsp_out_day;
   logic [3:0]  rsp_out_month;
   logic [11:0] rsp_out_year;
   logic        rsp_has_record;
   logic        rsp_final_res;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [11:0] csr_year_limit = '0;

   date_order_board board;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int quiet_cycles = 0;

   date_record_sorter_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_tag(req_tag),
      .req_day(req_day),
      .req_month(req_month),
      .req_year(req_year),
      .req_is_last(req_is_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_position(rsp_position),
      .rsp_out_tag(rsp_out_tag),
      .rsp_out_day(rsp_out_day),
      .rsp_out_month(rsp_out_month),
      .rsp_out_year(rsp_out_year),
      .rsp_has_record(rsp_has_record),
      .rsp_final_res(rsp_final_res),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_year_limit(csr_year_limit)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      dated_entry_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.position = rsp_position;
         seen.tag = rsp_out_tag;
         seen.day = rsp_out_day;
         seen.month = rsp_out_month;
         seen.year = rsp_out_year;
         seen.has_record = rsp_has_record;
         seen.final_res = rsp_final_res;
         board.check_result(seen);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_record(input rec_type r, input logic last);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_tag <= r.tag;
      req_day <= r.day;
      req_month <= r.month;
      req_year <= r.year;
      req_is_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_record(r, last);
   endtask

   task automatic write_year_limit(input logic [11:0] value);
      csr_valid <= 1'b1;
      csr_year_limit <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board.year_limit = value;
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   function automatic rec_type random_record();
      rec_type r;
      int      lim;
      int      y;
      lim = int'(board.year_limit);
      r.tag = 8'($urandom_range(0, 255));
      r.day = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(32, 63) :
                                               $urandom_range(0, 31));
      r.month = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(13, 15) :
                                                 $urandom_range(0, 12));
      case ($urandom_range(0, 3))
         0, 1: y = $urandom_range(0, lim);
         2: y = lim - 2 + int'($urandom_range(0, 4));
         default: y = $urandom_range(0, 4095);
      endcase
      if (y < 0) y = 0;
      if (y > 4095) y = 4095;
      r.year = y[11:0];
      return r;
   endfunction

   // Each batch ends with a last-marked record; about a quarter of the
   // records repeat the key of an earlier one in the same batch.
   task automatic run_batches(input int item_goal, input int big_size);
      rec_type held[$];
      rec_type r;
      int      sent;
      int      size;
      sent = 0;
      while (sent < item_goal) begin
         if (big_size > 0) begin
            size = big_size;
            big_size = 0;
         end else if ($urandom_range(0, 6) == 0) begin
            size = $urandom_range(9, 24);
         end else begin
            size = $urandom_range(1, 8);
         end
         held.delete();
         for (int k = 0; k < size; k++) begin
            r = random_record();
            if (held.size() > 0 && $urandom_range(0, 3) == 0) begin
               r = held[$urandom_range(0, held.size() - 1)];
               r.tag = 8'($urandom_range(0, 255));
            end
            held.push_back(r);
            send_record(r, k == size - 1);
         end
         sent += size;
         if ($urandom_range(0, 7) == 0) begin
            settle_block();
         end
      end
   endtask

   initial begin
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_record({8'hFF, 6'd31, 4'd12, 12'd2023}, 1'b1);

      send_record({8'd0, 6'd32, 4'd1, 12'd2000}, 1'b0);
      send_record({8'd1, 6'd1, 4'd13, 12'd2000}, 1'b0);
      send_record({8'd2, 6'd1, 4'd1, 12'd2024}, 1'b0);
      send_record({8'd3, 6'd63, 4'd15, 12'd4095}, 1'b1);

      send_record({8'd10, 6'd0, 4'd0, 12'd0}, 1'b0);
      send_record({8'd11, 6'd15, 4'd6, 12'd2000}, 1'b0);
      send_record({8'd12, 6'd15, 4'd6, 12'd2000}, 1'b0);
      send_record({8'd13, 6'd40, 4'd6, 12'd2000}, 1'b0);
      send_record({8'd14, 6'd31, 4'd12, 12'd2023}, 1'b0);
      send_record({8'd15, 6'd1, 4'd1, 12'd4095}, 1'b0);
      send_record({8'd16, 6'd0, 4'd0, 12'd0}, 1'b0);
      send_record({8'd17, 6'd5, 4'd14, 12'd1500}, 1'b0);
      send_record({8'd18, 6'd7, 4'd3, 12'd1999}, 1'b0);
      send_record({8'd19, 6'd15, 4'd6, 12'd2000}, 1'b1);

      send_record({8'd20, 6'd0, 4'd0, 12'd2024}, 1'b1);

      send_record({8'hAA, 6'd3, 4'd4, 12'd1234}, 1'b0);
      send_record({8'h55, 6'd2, 4'd4, 12'd1234}, 1'b1);
      settle_block();

      write_year_limit(12'd4095);
      run_batches(73, 68);
      settle_block();

      sender_idle_pct = 86;
      write_year_limit(12'd0);
      run_batches(73, 0);
      settle_block();

      sender_idle_pct = 0;
      receiver_stall_pct = 86;
      write_year_limit(12'($urandom_range(1, 4094)));
      run_batches(73, 64);
      settle_block();

      sender_idle_pct = 34;
      receiver_stall_pct = 34;
      write_year_limit(12'd2023);
      run_batches(73, 0);
      settle_block();

      repeat (64) @(posedge clock);
      if (board.errors == 0 && board.awaited.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+design
design/dsort_pkg.sv
design/date_record_sorter_unit.sv
bench/date_record_sorter_unit_test.sv
